// ----- hw/rtl/bec_pkg.sv -----
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types and constants of the bipartite edge colouring block.
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam int VERTICES = 64;
    localparam int VW       = $clog2(VERTICES);
    localparam int SLOT_W   = VW + 1;
    localparam int TAB_AW   = 2 * VW;
    localparam int TAB_DEPTH = VERTICES * VERTICES;
    localparam int SCAN_W   = VW + 2;
    localparam int CNT_W    = VW + 1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SELF_LOOP = 2'd1;
    localparam logic [1:0] ST_NO_COLOUR = 2'd2;
    localparam logic [1:0] ST_NON_BIP   = 2'd3;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ_W,
        S_SCAN,
        S_DECIDE,
        S_WALK_W,
        S_FL_A,
        S_FL_B,
        S_FL_C,
        S_FL_D,
        S_FL_E,
        S_GIVE_A,
        S_GIVE_B,
        S_DONE
    } bec_state_t;

endpackage

// ----- hw/rtl/bec_ram.sv -----
// ----------------------------------------------------------------------------
// bec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/bipartite_edge_colouring_top.sv -----
// ----------------------------------------------------------------------------
// bipartite_edge_colouring_top
// Online proper edge colouring of a bipartite graph with chain flipping.
// ----------------------------------------------------------------------------
// Input words carry a command in s_tuser (0 add edge, 1 read slot) and the
// two vertices and the colour index in s_tdata. Every input word gives one
// result word: status in m_tuser, colour, swap count, slot contents and the
// colour count in m_tdata.
// The vertex-by-colour table is one RAM port pair, and every step goes
// through it one access a cycle. A read passes S_READ_W and S_DONE; a self
// loop goes straight to S_DONE. An add scans both ends over all colours and,
// with no common free colour, walks the alternating chain one chain edge a
// cycle and flips it in S_FL_A to S_FL_E per vertex; S_GIVE_A/B write the edge.
// s_tready is high only when the sequencer is idle.
// After reset a clearing pass over all 4096 entries empties the table; no word is
// accepted meanwhile. A finished result waits in the output register while
// m_tready is low, and the next input word may still be accepted; a further
// result then waits until the output register drains.
// ----------------------------------------------------------------------------
module bipartite_edge_colouring_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // vertex_a[5:0], vertex_b[11:6], colour_index[17:12]
    input  logic [0:0]  s_tuser,  // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // colour_given[5:0], recoloured_edges[11:6],
                                  // neighbour[17:12], slot_used[18], colours_used[25:19]
    output logic [1:0]  m_tuser   // status[1:0]
);
    import bec_pkg::*;

    bec_state_t state_reg, state_next;

    logic [TAB_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [VW-1:0]     a_reg, a_next, b_reg, b_next;
    logic [SCAN_W-1:0] cnt_reg, cnt_next;
    logic              f1_reg, f1_next, f2_reg, f2_next, fc_reg, fc_next;
    logic [VW-1:0]     c1_reg, c1_next, c2_reg, c2_next, cc_reg, cc_next;
    logic              afree_reg, afree_next;
    logic [CNT_W-1:0]  n_reg, n_next, i_reg, i_next;
    logic [VW-1:0]     col_reg, col_next, oth_reg, oth_next;
    logic [VW-1:0]     v_reg, v_next, gcol_reg, gcol_next;
    logic [SLOT_W-1:0] s1_reg, s1_next;
    logic [SLOT_W-1:0] max_reg, max_next;
    logic [1:0]        rst_reg, rst_next;
    logic [VW-1:0]     rcol_reg, rcol_next, rrec_reg, rrec_next, rnb_reg, rnb_next;
    logic              rused_reg, rused_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    logic              t_we;
    logic [TAB_AW-1:0] t_waddr, t_raddr;
    logic [SLOT_W-1:0] t_wdata, t_rdata;
    logic              c_we;
    logic [VW-1:0]     c_waddr, c_wdata, c_rdata;

    logic [SCAN_W-1:0] pidx;
    logic              slot_free;
    logic [VW-1:0]     nx;

    bec_ram #(.WIDTH(SLOT_W), .DEPTH(TAB_DEPTH)) u_table (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    bec_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_chain (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(i_reg[VW-1:0]), .rdata(c_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign pidx      = cnt_reg - SCAN_W'(1);
    assign slot_free = !t_rdata[SLOT_W-1];
    assign nx        = t_rdata[VW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
        a_reg     <= a_next;
        b_reg     <= b_next;
        cnt_reg   <= cnt_next;
        f1_reg    <= f1_next;
        f2_reg    <= f2_next;
        fc_reg    <= fc_next;
        c1_reg    <= c1_next;
        c2_reg    <= c2_next;
        cc_reg    <= cc_next;
        afree_reg <= afree_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        col_reg   <= col_next;
        oth_reg   <= oth_next;
        v_reg     <= v_next;
        gcol_reg  <= gcol_next;
        s1_reg    <= s1_next;
        rst_reg   <= rst_next;
        rcol_reg  <= rcol_next;
        rrec_reg  <= rrec_next;
        rnb_reg   <= rnb_next;
        rused_reg <= rused_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        a_next = a_reg; b_next = b_reg;
        cnt_next = cnt_reg;
        f1_next = f1_reg; f2_next = f2_reg; fc_next = fc_reg;
        c1_next = c1_reg; c2_next = c2_reg; cc_next = cc_reg;
        afree_next = afree_reg;
        n_next = n_reg; i_next = i_reg;
        col_next = col_reg; oth_next = oth_reg;
        v_next = v_reg; gcol_next = gcol_reg; s1_next = s1_reg;
        max_next = max_reg;
        rst_next = rst_reg; rcol_next = rcol_reg; rrec_next = rrec_reg;
        rnb_next = rnb_reg; rused_next = rused_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        t_we    = 1'b0;
        t_waddr = '0;
        t_wdata = '0;
        t_raddr = '0;
        c_we    = 1'b0;
        c_waddr = '0;
        c_wdata = '0;

        unique case (state_reg)
            S_CLEAR: begin
                t_we         = 1'b1;
                t_waddr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + TAB_AW'(1);
                if (clr_cnt_reg == {TAB_AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                a_next  = s_tdata[VW-1:0];
                b_next  = s_tdata[2*VW-1:VW];
                rst_next = ST_OK; rcol_next = '0; rrec_next = '0;
                rnb_next = '0; rused_next = 1'b0;
                cnt_next = '0;
                f1_next = 1'b0; f2_next = 1'b0; fc_next = 1'b0;
                t_raddr = {s_tdata[VW-1:0], s_tdata[3*VW-1:2*VW]};
                if (s_tvalid) begin
                    if (s_tuser[0] == CMD_READ) begin
                        state_next = S_READ_W;
                    end else if (s_tdata[VW-1:0] == s_tdata[2*VW-1:VW]) begin
                        rst_next   = ST_SELF_LOOP;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_READ_W: begin
                rused_next = !slot_free;
                rnb_next   = slot_free ? '0 : nx;
                state_next = S_DONE;
            end
            S_SCAN: begin
                t_raddr  = {cnt_reg[0] ? b_reg : a_reg, cnt_reg[VW:1]};
                cnt_next = cnt_reg + SCAN_W'(1);
                if (cnt_reg != '0) begin
                    if (!pidx[0]) begin
                        afree_next = slot_free;
                        if (slot_free && !f1_reg) begin
                            f1_next = 1'b1;
                            c1_next = pidx[VW:1];
                        end
                    end else begin
                        if (slot_free && !f2_reg) begin
                            f2_next = 1'b1;
                            c2_next = pidx[VW:1];
                        end
                        if (slot_free && afree_reg && !fc_reg) begin
                            fc_next = 1'b1;
                            cc_next = pidx[VW:1];
                        end
                    end
                end
                if (cnt_reg[SCAN_W-1]) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                c_waddr  = '0;
                c_wdata  = b_reg;
                n_next   = CNT_W'(1);
                col_next = c1_reg;
                oth_next = c2_reg;
                t_raddr  = {b_reg, c1_reg};
                if (fc_reg) begin
                    gcol_next  = cc_reg;
                    state_next = S_GIVE_A;
                end else if (!f1_reg || !f2_reg) begin
                    rst_next   = ST_NO_COLOUR;
                    state_next = S_DONE;
                end else begin
                    c_we       = 1'b1;
                    gcol_next  = c1_reg;
                    state_next = S_WALK_W;
                end
            end
            S_WALK_W: begin
                if (slot_free) begin
                    i_next     = '0;
                    state_next = S_FL_A;
                end else if (nx == a_reg || n_reg[CNT_W-1]) begin
                    rst_next   = ST_NON_BIP;
                    state_next = S_DONE;
                end else begin
                    c_we     = 1'b1;
                    c_waddr  = n_reg[VW-1:0];
                    c_wdata  = nx;
                    n_next   = n_reg + CNT_W'(1);
                    col_next = oth_reg;
                    oth_next = col_reg;
                    t_raddr  = {nx, oth_reg};
                end
            end
            S_FL_A: begin
                state_next = S_FL_B;
            end
            S_FL_B: begin
                v_next     = c_rdata;
                t_raddr    = {c_rdata, c1_reg};
                state_next = S_FL_C;
            end
            S_FL_C: begin
                s1_next    = t_rdata;
                t_raddr    = {v_reg, c2_reg};
                state_next = S_FL_D;
            end
            S_FL_D: begin
                t_we       = 1'b1;
                t_waddr    = {v_reg, c1_reg};
                t_wdata    = t_rdata;
                state_next = S_FL_E;
            end
            S_FL_E: begin
                t_we    = 1'b1;
                t_waddr = {v_reg, c2_reg};
                t_wdata = s1_reg;
                i_next  = i_reg + CNT_W'(1);
                if (i_reg + CNT_W'(1) == n_reg) begin
                    state_next = S_GIVE_A;
                end else begin
                    state_next = S_FL_A;
                end
            end
            S_GIVE_A: begin
                t_we      = 1'b1;
                t_waddr   = {a_reg, gcol_reg};
                t_wdata   = {1'b1, b_reg};
                rrec_next = fc_reg ? '0 : VW'(n_reg - CNT_W'(1));
                if ({1'b0, gcol_reg} + SLOT_W'(1) > max_reg) begin
                    max_next = {1'b0, gcol_reg} + SLOT_W'(1);
                end
                state_next = S_GIVE_B;
            end
            S_GIVE_B: begin
                t_we       = 1'b1;
                t_waddr    = {b_reg, gcol_reg};
                t_wdata    = {1'b1, a_reg};
                rst_next   = ST_OK;
                rcol_next  = gcol_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = rst_reg;
                    m_data_next  = {6'd0, max_reg, rused_reg, rnb_reg, rrec_reg, rcol_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (cnt_reg <= SCAN_W'(2 * VERTICES)))
        else $error("scan counter overran");
    a_chain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK_W) |-> (n_reg <= CNT_W'(VERTICES)))
        else $error("chain length overran");
    a_give_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GIVE_A) |-> (fc_reg || (f1_reg && f2_reg)))
        else $error("edge written without a free colour");
    a_fail_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg != ST_OK) |-> (m_data_reg[2*VW-1:0] == '0))
        else $error("failed add reports a colour");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the bipartite edge colouring block word by word against a predictor.
// ----------------------------------------------------------------------------
// A directed table covers reset readback, self loops, extremes, short chains
// and odd cycles, then a full vertex. Random traffic then builds graphs
// on two vertex halves (mostly bipartite, some noise), mixed with slot reads,
// while both sides insert random gaps. Every result word is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import bec_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] colour;
        logic [5:0] swaps;
        logic [5:0] nbr;
        logic       used;
        logic [6:0] ncol;
    } edge_res_t;

    typedef struct {
        logic       cmd;
        logic [5:0] va;
        logic [5:0] vb;
        logic [5:0] ci;
        logic       known;
        edge_res_t  res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    bipartite_edge_colouring_top dut (.*);

    initial forever #1 aclk = ~aclk;

    logic       tbl_used [VERTICES][VERTICES];
    logic [5:0] tbl_nbr  [VERTICES][VERTICES];
    int         top_colour;
    edge_res_t  pending [$];
    int         errors = 0;
    int         n_sent = 0, n_flips = 0, n_nonbip = 0, n_full = 0;
    dir_row_t   dir [$];

    function automatic edge_res_t colour_edge(logic cmd, int a, int b, int ci);
        edge_res_t r;
        int c, c1, c2, cur, col, oth, t, n, nx;
        int path [VERTICES];
        logic f1, f2, sv;
        logic [5:0] sn;
        r = '0;
        if (cmd == CMD_READ) begin
            if (tbl_used[a][ci]) begin
                r.used = 1'b1;
                r.nbr = tbl_nbr[a][ci];
            end
            r.ncol = 7'(top_colour);
            return r;
        end
        if (a == b) begin
            r.status = ST_SELF_LOOP;
            r.ncol = 7'(top_colour);
            return r;
        end
        for (c = 0; c < VERTICES; c++) begin
            if (!tbl_used[a][c] && !tbl_used[b][c]) begin
                tbl_used[a][c] = 1; tbl_nbr[a][c] = 6'(b);
                tbl_used[b][c] = 1; tbl_nbr[b][c] = 6'(a);
                if (c + 1 > top_colour) top_colour = c + 1;
                r.colour = 6'(c);
                r.ncol = 7'(top_colour);
                return r;
            end
        end
        f1 = 0; f2 = 0; c1 = 0; c2 = 0;
        for (c = 0; c < VERTICES; c++) begin
            if (!f1 && !tbl_used[a][c]) begin c1 = c; f1 = 1; end
            if (!f2 && !tbl_used[b][c]) begin c2 = c; f2 = 1; end
        end
        if (!f1 || !f2) begin
            r.status = ST_NO_COLOUR;
            r.ncol = 7'(top_colour);
            n_full++;
            return r;
        end
        path[0] = b; n = 1; cur = b; col = c1; oth = c2;
        while (tbl_used[cur][col]) begin
            nx = int'(tbl_nbr[cur][col]);
            if (nx == a || n >= VERTICES) begin
                r.status = ST_NON_BIP;
                r.ncol = 7'(top_colour);
                n_nonbip++;
                return r;
            end
            path[n] = nx; n++; cur = nx;
            t = col; col = oth; oth = t;
        end
        for (int i = 0; i < n; i++) begin
            sv = tbl_used[path[i]][c1]; sn = tbl_nbr[path[i]][c1];
            tbl_used[path[i]][c1] = tbl_used[path[i]][c2];
            tbl_nbr[path[i]][c1] = tbl_nbr[path[i]][c2];
            tbl_used[path[i]][c2] = sv; tbl_nbr[path[i]][c2] = sn;
        end
        tbl_used[a][c1] = 1; tbl_nbr[a][c1] = 6'(b);
        tbl_used[b][c1] = 1; tbl_nbr[b][c1] = 6'(a);
        if (c1 + 1 > top_colour) top_colour = c1 + 1;
        if (n > 1) n_flips++;
        r.colour = 6'(c1);
        r.swaps = 6'(n - 1);
        r.ncol = 7'(top_colour);
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_word(logic cmd, int a, int b, int ci, logic known, edge_res_t r);
        edge_res_t p;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, 6'(ci), 6'(b), 6'(a)};
        do @(posedge aclk); while (!s_tready);
        p = colour_edge(cmd, a, b, ci);
        if (known && p !== r) begin
            errors++;
            if (errors <= 10)
                $display("table row %0d: typed %h predicted %h", n_sent, r, p);
        end
        pending = {pending, p};
        n_sent++;
    endtask

    task automatic add_row(logic cmd, int a, int b, int ci, logic known = 0,
                           logic [1:0] st = ST_OK, int col = 0, int nb = 0,
                           logic used = 0, int nc = 0);
        dir_row_t d;
        d.cmd = cmd; d.va = 6'(a); d.vb = 6'(b); d.ci = 6'(ci); d.known = known;
        d.res = '{st, 6'(col), 6'd0, 6'(nb), used, 7'(nc)};
        dir = {dir, d};
    endtask

    // Result side: random backpressure and compare.
    initial begin
        edge_res_t got, want;
        int stall;
        @(posedge aresetn);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[5:0], m_tdata[11:6], m_tdata[17:12],
                        m_tdata[18], m_tdata[25:19]};
                if (pending.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %h", got);
                end else begin
                    want = pending.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
        end
    end

    initial begin
        int a, b, k;
        for (int v = 0; v < VERTICES; v++)
            for (int c = 0; c < VERTICES; c++) begin
                tbl_used[v][c] = 0; tbl_nbr[v][c] = '0;
            end
        top_colour = 0;
        add_row(CMD_READ, 0, 0, 0, 1);
        add_row(CMD_READ, 63, 0, 63, 1);
        add_row(CMD_ADD, 5, 5, 0, 1, ST_SELF_LOOP);
        add_row(CMD_ADD, 0, 63, 0, 1, ST_OK, 0, 0, 0, 1);
        add_row(CMD_READ, 63, 0, 0, 1, ST_OK, 0, 0, 1, 1);
        add_row(CMD_ADD, 63, 0, 0, 1, ST_OK, 1, 0, 0, 2);
        add_row(CMD_ADD, 1, 2, 0);
        add_row(CMD_ADD, 3, 4, 0);
        add_row(CMD_ADD, 3, 2, 0);
        add_row(CMD_ADD, 1, 4, 0);
        add_row(CMD_ADD, 5, 2, 0);
        add_row(CMD_ADD, 1, 6, 0);
        add_row(CMD_ADD, 7, 8, 0);
        add_row(CMD_ADD, 8, 9, 0);
        add_row(CMD_ADD, 9, 7, 0);
        add_row(CMD_ADD, 10, 11, 0);
        add_row(CMD_ADD, 11, 12, 0);
        add_row(CMD_ADD, 10, 12, 0);
        add_row(CMD_READ, 2, 0, 1);
        add_row(CMD_READ, 42, 0, 21);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (dir[i])
            send_word(dir[i].cmd, dir[i].va, dir[i].vb, dir[i].ci, dir[i].known, dir[i].res);
        // fill vertex 20 with an edge to every other vertex, then add more edges on it
        for (int j = 0; j < VERTICES; j++)
            if (j != 20) send_word(CMD_ADD, 20, j, 0, 0, '0);
        send_word(CMD_ADD, 30, 20, 0, 0, '0);
        send_word(CMD_ADD, 20, 31, 0, 0, '0);
        send_word(CMD_ADD, 20, 32, 0, 0, '0);
        send_word(CMD_READ, 20, 0, 63, 0, '0);
        for (int i = 0; i < 2000; i++) begin
            k = $urandom_range(0, 99);
            if (i % 500 == 0 && i > 0) k = 200;
            if (k < 15) begin
                send_word(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 63), 0, '0);
            end else if (k < 90) begin
                a = 2 * $urandom_range(0, 31);
                b = 2 * $urandom_range(0, 31) + 1;
                if ($urandom_range(0, 1)) send_word(CMD_ADD, a, b, 0, 0, '0);
                else send_word(CMD_ADD, b, a, 0, 0, '0);
            end else if (k < 100) begin
                send_word(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 63), 0, '0);
            end else begin
                // put a burst of edges from a random vertex to random vertices
                a = $urandom_range(0, 63);
                for (int j = 0; j < 8; j++)
                    send_word(CMD_ADD, a, $urandom_range(0, 63), 0, 0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("sent %0d words: %0d chain flips, %0d non-bipartite, %0d full vertex",
                 n_sent, n_flips, n_nonbip, n_full);
        $display("highest colour count reached %0d", top_colour);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout with %0d words outstanding", pending.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
